// ===== sv/scp_pkg.sv =====
// scp_pkg: event codes, character constants, field widths and the number
// decoder shared by the serial command parser.
// No dependencies.
`timescale 1ns / 1ps

package scp_pkg;

	localparam int unsigned EVENT_W = 3;
	localparam int unsigned TIME_W  = 12;
	localparam int unsigned BRIGHT_W = 7;
	localparam int unsigned NUM_W   = 14;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE        = 3'd0,
		EV_CLEAR       = 3'd1,
		EV_HELP        = 3'd2,
		EV_PHRASE_DONE = 3'd3,
		EV_TIME_SET    = 3'd4,
		EV_TIME_ERR    = 3'd5,
		EV_BRIGHT_SET  = 3'd6,
		EV_BRIGHT_ERR  = 3'd7
	} event_t;

	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_SPACE_CODE = 8'h40;
	localparam logic [7:0] CH_DASH       = 8'h2D;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_C          = 8'h43;
	localparam logic [7:0] CH_H          = 8'h48;
	localparam logic [7:0] CH_W          = 8'h57;
	localparam logic [7:0] CH_T          = 8'h54;
	localparam logic [7:0] CH_B          = 8'h42;

	localparam logic [2:0] TIME_CAP   = 3'd4;
	localparam logic [1:0] BRIGHT_CAP = 2'd3;

	localparam logic [TIME_W-1:0]   TIME_RST   = 12'd1000;
	localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 7'd50;
	localparam logic [NUM_W-1:0]    TIME_MIN   = 14'd10;
	localparam logic [NUM_W-1:0]    TIME_MAX   = 14'd4000;
	localparam logic [NUM_W-1:0]    BRIGHT_MIN = 14'd14;
	localparam logic [NUM_W-1:0]    BRIGHT_MAX = 14'd100;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] val;
	} num_t;

	// atoi-style decode of up to four buffered characters
	function automatic num_t decode_num(input logic [3:0][7:0] chars,
	                                    input logic [2:0] n);
		num_t       r;
		logic       started;
		logic       stop;
		logic [7:0] c;
		r       = '0;
		started = 1'b0;
		stop    = 1'b0;
		for (int i = 0; i < 4; i++) begin
			c = chars[i];
			if (!stop && (3'(i) < n)) begin
				if (c >= 8'h30 && c <= 8'h39) begin
					r.val   = NUM_W'(r.val * NUM_W'(10)) + NUM_W'(c - 8'h30);
					started = 1'b1;
				end else if (!started && c >= 8'h09 && c <= 8'h0C) begin
					started = 1'b0;
				end else if (!started && (c == CH_PLUS || c == CH_DASH)) begin
					r.neg   = (c == CH_DASH);
					started = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/serial_command_parser_unit.sv =====
// serial_command_parser_unit: parses received serial bytes into clear, help,
// phrase-store, display time and brightness commands.
// Depends on scp_pkg.
`timescale 1ns / 1ps

//  channel | signals                         | dir | transaction
//  --------+---------------------------------+-----+------------------------------
//  in      | in_valid, in_ready, rx_byte     | in  | one received byte
//  out     | out_valid, out_ready, event_res,| out | one result per byte
//          | phrase_wr_*, phrase_length,     |     |
//          | display_time_ms, brightness_pct |     |
//
// Input to result: byte register, then parse logic into the result register.
// One byte per cycle sustained while no result stalls; parse state updates
// as a byte moves into the result register. A stalled result holds the byte
// register, which stalls the input. Reset clears all control state and
// restores phrase length 1, time 1000 ms, brightness 50 percent.

module serial_command_parser_unit #(
	parameter int unsigned PHRASE_DEPTH = 64,
	localparam int unsigned IDX_W = $clog2(PHRASE_DEPTH),
	localparam int unsigned LEN_W = $clog2(PHRASE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [scp_pkg::EVENT_W-1:0]   event_res,
	output logic                          phrase_wr_en,
	output logic [IDX_W-1:0]              phrase_wr_index,
	output logic [7:0]                    phrase_wr_char,
	output logic [LEN_W-1:0]              phrase_length,
	output logic [scp_pkg::TIME_W-1:0]    display_time_ms,
	output logic [scp_pkg::BRIGHT_W-1:0]  brightness_pct
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       adv;

	logic                          valid_s2;
	scp_pkg::event_t               event_s2;
	logic                          wr_en_s2;
	logic [IDX_W-1:0]              wr_index_s2;
	logic [7:0]                    wr_char_s2;
	logic [LEN_W-1:0]              length_s2;
	logic [scp_pkg::TIME_W-1:0]    time_s2;
	logic [scp_pkg::BRIGHT_W-1:0]  bright_s2;

	logic                          command_armed_q;
	logic                          phrase_entry_q;
	logic                          time_entry_q;
	logic                          bright_entry_q;
	logic [LEN_W-1:0]              phrase_end_q;
	logic [2:0]                    time_count_q;
	logic [1:0]                    bright_count_q;
	logic [scp_pkg::TIME_W-1:0]    time_value_q;
	logic [scp_pkg::BRIGHT_W-1:0]  bright_value_q;
	logic [7:0]                    time_chars_q [4];
	logic [7:0]                    bright_chars_q [3];

	logic                          command_armed_n;
	logic                          phrase_entry_n;
	logic                          time_entry_n;
	logic                          bright_entry_n;
	logic [LEN_W-1:0]              phrase_end_n;
	logic [2:0]                    time_count_n;
	logic [1:0]                    bright_count_n;
	logic [scp_pkg::TIME_W-1:0]    time_value_n;
	logic [scp_pkg::BRIGHT_W-1:0]  bright_value_n;
	logic                          time_wr;
	logic                          bright_wr;
	scp_pkg::event_t               ev;
	logic                          wen;
	logic [IDX_W-1:0]              widx;
	logic [7:0]                    wch;
	logic [7:0]                    b;
	logic                          done;
	scp_pkg::num_t                 time_num;
	scp_pkg::num_t                 bright_num;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	assign time_num = scp_pkg::decode_num({time_chars_q[3], time_chars_q[2],
		time_chars_q[1], time_chars_q[0]}, time_count_q);
	assign bright_num = scp_pkg::decode_num({8'h00, bright_chars_q[2],
		bright_chars_q[1], bright_chars_q[0]}, {1'b0, bright_count_q});

	always_comb begin
		b = (rx_byte_s1 == scp_pkg::CH_SPACE) ? scp_pkg::CH_SPACE_CODE : rx_byte_s1;
		command_armed_n = command_armed_q || (b == scp_pkg::CH_DASH);
		phrase_entry_n  = phrase_entry_q;
		time_entry_n    = time_entry_q;
		bright_entry_n  = bright_entry_q;
		phrase_end_n    = phrase_end_q;
		time_count_n    = time_count_q;
		bright_count_n  = bright_count_q;
		time_value_n    = time_value_q;
		bright_value_n  = bright_value_q;
		time_wr         = 1'b0;
		bright_wr       = 1'b0;
		ev              = scp_pkg::EV_NONE;
		wen             = 1'b0;
		widx            = '0;
		wch             = '0;
		done            = 1'b0;

		if (command_armed_n) begin
			case (b)
				scp_pkg::CH_C: begin
					phrase_end_n = LEN_W'(1);
					ev           = scp_pkg::EV_CLEAR;
					done         = 1'b1;
				end
				scp_pkg::CH_H: begin
					ev   = scp_pkg::EV_HELP;
					done = 1'b1;
				end
				scp_pkg::CH_W: begin
					phrase_entry_n  = 1'b1;
					phrase_end_n    = LEN_W'(1);
					command_armed_n = 1'b0;
					done            = 1'b1;
				end
				scp_pkg::CH_T: begin
					time_entry_n    = 1'b1;
					time_count_n    = '0;
					command_armed_n = 1'b0;
					done            = 1'b1;
				end
				scp_pkg::CH_B: begin
					bright_entry_n  = 1'b1;
					bright_count_n  = '0;
					command_armed_n = 1'b0;
					done            = 1'b1;
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end

		if (!done && phrase_entry_q) begin
			if (b == scp_pkg::CH_SPACE_CODE && phrase_end_q == LEN_W'(1)) begin
				done = 1'b1;
			end else if (b == scp_pkg::CH_CR) begin
				phrase_entry_n = 1'b0;
				ev             = scp_pkg::EV_PHRASE_DONE;
				done           = 1'b1;
			end else if (phrase_end_q < LEN_W'(PHRASE_DEPTH)) begin
				wen          = 1'b1;
				widx         = phrase_end_q[IDX_W-1:0];
				wch          = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'h20) : b;
				phrase_end_n = phrase_end_q + LEN_W'(1);
			end
		end

		if (!done && time_entry_q) begin
			if (b == scp_pkg::CH_SPACE_CODE) begin
				done = 1'b1;
			end else if (b == scp_pkg::CH_CR) begin
				if (!time_num.neg && time_num.val >= scp_pkg::TIME_MIN &&
						time_num.val <= scp_pkg::TIME_MAX) begin
					time_value_n = time_num.val[scp_pkg::TIME_W-1:0];
					ev           = scp_pkg::EV_TIME_SET;
				end else begin
					ev = scp_pkg::EV_TIME_ERR;
				end
				time_entry_n = 1'b0;
				done         = 1'b1;
			end else if (time_count_q < scp_pkg::TIME_CAP) begin
				time_wr      = 1'b1;
				time_count_n = time_count_q + 3'd1;
			end
		end

		if (!done && bright_entry_q) begin
			if (b == scp_pkg::CH_SPACE_CODE) begin
				done = 1'b1;
			end else if (b == scp_pkg::CH_CR) begin
				if (!bright_num.neg && bright_num.val >= scp_pkg::BRIGHT_MIN &&
						bright_num.val <= scp_pkg::BRIGHT_MAX) begin
					bright_value_n = bright_num.val[scp_pkg::BRIGHT_W-1:0];
					ev             = scp_pkg::EV_BRIGHT_SET;
				end else begin
					ev = scp_pkg::EV_BRIGHT_ERR;
				end
				bright_entry_n = 1'b0;
				done           = 1'b1;
			end else if (bright_count_q < scp_pkg::BRIGHT_CAP) begin
				bright_wr      = 1'b1;
				bright_count_n = bright_count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_armed_q <= 1'b0;
			phrase_entry_q  <= 1'b0;
			time_entry_q    <= 1'b0;
			bright_entry_q  <= 1'b0;
			phrase_end_q    <= LEN_W'(1);
			time_count_q    <= '0;
			bright_count_q  <= '0;
			time_value_q    <= scp_pkg::TIME_RST;
			bright_value_q  <= scp_pkg::BRIGHT_RST;
		end else if (valid_s1 && adv) begin
			command_armed_q <= command_armed_n;
			phrase_entry_q  <= phrase_entry_n;
			time_entry_q    <= time_entry_n;
			bright_entry_q  <= bright_entry_n;
			phrase_end_q    <= phrase_end_n;
			time_count_q    <= time_count_n;
			bright_count_q  <= bright_count_n;
			time_value_q    <= time_value_n;
			bright_value_q  <= bright_value_n;
		end
	end

	// entry buffers: only entries below the count are ever read
	always_ff @(posedge clk) begin
		if (valid_s1 && adv && time_wr) begin
			time_chars_q[time_count_q[1:0]] <= b;
		end
		if (valid_s1 && adv && bright_wr) begin
			bright_chars_q[bright_count_q] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			event_s2    <= ev;
			wr_en_s2    <= wen;
			wr_index_s2 <= widx;
			wr_char_s2  <= wch;
			length_s2   <= phrase_end_n;
			time_s2     <= time_value_n;
			bright_s2   <= bright_value_n;
		end
	end

	assign out_valid       = valid_s2;
	assign event_res       = event_s2;
	assign phrase_wr_en    = wr_en_s2;
	assign phrase_wr_index = wr_index_s2;
	assign phrase_wr_char  = wr_char_s2;
	assign phrase_length   = length_s2;
	assign display_time_ms = time_s2;
	assign brightness_pct  = bright_s2;

endmodule
